/* design/frame_rate_meter_limiter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame rate meter/limiter checks
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_METER_LIMITER_ASSERT_SVH
`define FRAME_RATE_METER_LIMITER_ASSERT_SVH

// same-cycle implication
`define FRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/frm_pkg.sv */
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants of the frame rate meter/limiter.
// ----------------------------------------------------------------------------
package frm_pkg;

  localparam int NOW_W   = 32;
  localparam int FT_W    = 16;
  localparam int FPS_W   = 18;
  localparam int DELAY_W = 10;
  localparam int FPS_CFG_W = 10;
  localparam int SUM_W   = 20;
  localparam int FILL_W  = 4;   // window is at most 15 entries
  localparam int DIV_W   = 22;  // 15 * 256000 fits in 22 bits
  localparam int REM_W   = SUM_W + 1;
  localparam int STEP_W  = 5;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  localparam logic [FPS_CFG_W-1:0] MAX_FPS_RESET = 10'd60;
  localparam int FPS_SCALE   = 256000;
  localparam logic [FPS_W-1:0] FPS_SAT     = 18'd256000;
  localparam logic [FPS_W-1:0] FPS_DEFAULT = 18'd15360;

  localparam int PERIOD_NUM   = 1000;
  localparam logic [STEP_W-1:0] PERIOD_STEPS = 5'd10;
  localparam logic [STEP_W-1:0] FPS_STEPS    = 5'd22;
  // 1000 left-aligned so that ten steps leave the quotient in the low bits
  localparam logic [DIV_W-1:0] PERIOD_DIVIDEND =
    DIV_W'(PERIOD_NUM) << (DIV_W - 10);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RING   = 6'b000010,
    ST_PDIV   = 6'b000100,
    ST_FSTART = 6'b001000,
    ST_FDIV   = 6'b010000,
    ST_DONE   = 6'b100000
  } frm_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [SUM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } frm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } frm_div_rsp_t;

endpackage

/* design/frame_rate_meter_limiter.sv */
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter
// Moving-average frame rate meter and frame rate limiter (delay report).
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | in_command, in_now_ms
//  out      | out_valid / out_ready  | out_fps_q8, out_frame_time_ms,
//           |                        | out_delay_ms
//  cfg      | cfg_valid / cfg_ready  | cfg_max_fps (cfg_ready always high)
//
//  Begin: no result. End: in_ready low until the result is loaded into the output
//  register, which raises out_valid; ten shared-divider steps for the limiter period,
//  22 for the rate, and the sequencing states (ring, two done checks, launch, load).
//  An all-zero window skips the rate division.
//  A result waits in the output register while the next input is taken; a second
//  one holds the sequencer, and in_ready, until it drains. rst_n: sync, active low.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter
  import frm_pkg::*;
#(
  parameter int WINDOW = 10   // 1 to 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [NOW_W-1:0]     in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FPS_W-1:0]     out_fps_q8,
  output logic [FT_W-1:0]      out_frame_time_ms,
  output logic [DELAY_W-1:0]   out_delay_ms,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [FPS_CFG_W-1:0] cfg_max_fps
);

  frm_state_t state_r, state_nxt;

  // control state
  logic [FPS_CFG_W-1:0] max_fps_r;
  logic [NOW_W-1:0]     frame_start_r;
  logic [NOW_W-1:0]     previous_end_r;
  logic                 seen_end_r;
  logic                 out_valid_r;

  // per-item working registers
  logic [NOW_W-1:0]   elapsed_r;
  logic [FT_W-1:0]    ft_r;
  logic [DELAY_W-1:0] delay_r;
  logic [FPS_W-1:0]   fps_r;
  logic [FPS_W-1:0]   out_fps_r;
  logic [FT_W-1:0]    out_ft_r;
  logic [DELAY_W-1:0] out_delay_r;

  logic               in_xfer;
  logic               end_xfer;
  logic [NOW_W-1:0]   diff;
  logic [FT_W-1:0]    ft_new;
  logic [FPS_CFG_W-1:0] lim;
  logic [DELAY_W-1:0] period;
  logic               load_out;

  frm_div_req_t       div_req;
  frm_div_rsp_t       div_rsp;
  logic [SUM_W-1:0]   ring_sum;
  logic [FILL_W-1:0]  ring_fill;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign end_xfer  = in_xfer && (in_command == CMD_END);

  // frame time: wrapping difference, saturated; zero on the first end
  assign diff   = in_now_ms - previous_end_r;
  assign ft_new = !seen_end_r         ? '0 :
                  (diff[NOW_W-1:FT_W] != '0) ? '1 : diff[FT_W-1:0];

  // a zero limit behaves as one frame per second
  assign lim    = (max_fps_r == '0) ? FPS_CFG_W'(1) : max_fps_r;
  assign period = div_rsp.quotient[DELAY_W-1:0];

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // divider requests: period in RING, rate in FSTART (skipped on zero sum)
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = PERIOD_DIVIDEND;
    div_req.divisor  = SUM_W'(lim);
    div_req.steps    = PERIOD_STEPS;
    if (state_r == ST_RING) begin
      div_req.start = 1'b1;
    end else if (state_r == ST_FSTART) begin
      div_req.start    = (ring_sum != '0);
      div_req.dividend = DIV_W'(ring_fill * FPS_SCALE);
      div_req.divisor  = ring_sum;
      div_req.steps    = FPS_STEPS;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (end_xfer) state_nxt = ST_RING;
      ST_RING:   state_nxt = ST_PDIV;
      ST_PDIV:   if (div_rsp.done) state_nxt = ST_FSTART;
      ST_FSTART: state_nxt = (ring_sum == '0) ? ST_DONE : ST_FDIV;
      ST_FDIV:   if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      max_fps_r      <= MAX_FPS_RESET;
      frame_start_r  <= '0;
      previous_end_r <= '0;
      seen_end_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        max_fps_r <= cfg_max_fps;
      end
      if (in_xfer && (in_command == CMD_BEGIN)) begin
        frame_start_r <= in_now_ms;
      end
      if (end_xfer) begin
        previous_end_r <= in_now_ms;
        seen_end_r     <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (end_xfer) begin
      ft_r      <= ft_new;
      elapsed_r <= in_now_ms - frame_start_r;
    end
    if ((state_r == ST_PDIV) && div_rsp.done) begin
      delay_r <= (NOW_W'(period) > elapsed_r) ? period - elapsed_r[DELAY_W-1:0] : '0;
    end
    if ((state_r == ST_FSTART) && (ring_sum == '0)) begin
      fps_r <= FPS_DEFAULT;
    end
    if ((state_r == ST_FDIV) && div_rsp.done) begin
      fps_r <= (div_rsp.quotient > DIV_W'(FPS_SAT)) ? FPS_SAT
                                                   : div_rsp.quotient[FPS_W-1:0];
    end
    if (load_out) begin
      out_fps_r   <= fps_r;
      out_ft_r    <= ft_r;
      out_delay_r <= delay_r;
    end
  end

  frm_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (state_r == ST_RING),
    .ft    (ft_r),
    .sum   (ring_sum),
    .fill  (ring_fill)
  );

  frm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid         = out_valid_r;
  assign out_fps_q8        = out_fps_r;
  assign out_frame_time_ms = out_ft_r;
  assign out_delay_ms      = out_delay_r;

endmodule

/* design/frm_div.sv */
// ----------------------------------------------------------------------------
// frm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frm_div
  import frm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  frm_div_req_t req,
  output frm_div_rsp_t rsp
);

  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [STEP_W-1:0] count_r;
  logic [SUM_W-1:0]  divisor_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign trial = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else if (req.start) begin
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
      count_r <= req.steps;
    end else if (busy_r) begin
      count_r <= count_r - 1'b1;
      if (count_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= '0;
      quo_r     <= req.dividend;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, divisor_r}) : trial;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* design/frm_ring.sv */
// ----------------------------------------------------------------------------
// frm_ring
// Ring of the last WINDOW frame times with running sum and fill count.
// ----------------------------------------------------------------------------
module frm_ring
  import frm_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [FT_W-1:0]   ft,
  output logic [SUM_W-1:0]  sum,
  output logic [FILL_W-1:0] fill
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [FT_W-1:0]   ring_r [WINDOW];
  logic [PTR_W-1:0]  ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic              full;
  logic [FT_W-1:0]   old_ft;

  assign full   = fill_r >= FILL_W'(WINDOW);
  assign old_ft = full ? ring_r[ptr_r] : '0;   // entry read only once written

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (push) begin
      sum_r  <= sum_r - SUM_W'(old_ft) + SUM_W'(ft);
      ptr_r  <= (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring_r[ptr_r] <= ft;
    end
  end

  assign sum  = sum_r;
  assign fill = fill_r;

endmodule

/* design/frm_checker.sv */
// ----------------------------------------------------------------------------
// frm_checker
// Port-level checks of the frame rate meter/limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_rate_meter_limiter_assert.svh"

module frm_checker
  import frm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_command,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FPS_W-1:0]   out_fps_q8,
  input logic [FT_W-1:0]    out_frame_time_ms,
  input logic [DELAY_W-1:0] out_delay_ms
);

  // stalled result holds
  `FRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fps_q8) && $stable(out_frame_time_ms) && $stable(out_delay_ms), "stalled result changed")
  // rate never above the saturation value
  `FRM_ASSERT_SAME(a_fps_range, out_valid, out_fps_q8 <= FPS_SAT, "fps above saturation")
  // delay never above one second
  `FRM_ASSERT_SAME(a_delay_range, out_valid, out_delay_ms <= DELAY_W'(1000), "delay above 1000 ms")
  // a begin transfer with no result pending raises no result
  `FRM_ASSERT_NEXT(a_begin_silent, in_valid && in_ready && (in_command == CMD_BEGIN) && !out_valid, !out_valid, "begin produced a result")

endmodule

bind frame_rate_meter_limiter frm_checker u_frm_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: frame rate meter/limiter testbench
// Drives begin/end frame events into frame_rate_meter_limiter and checks
// every result against a cycle-free predictor of frame time, averaged rate
// and limiter delay. Directed cases first, then randomized frame sequences
// under several max_fps settings, bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import frm_pkg::*;

  localparam int RING_DEPTH        = 10;
  localparam int SETTLE_CYCLES     = 48;    // enough for one end transfer to finish
  localparam int TAIL_CYCLES       = 60;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int WATCHDOG_LIMIT    = 4000;  // cycles without any transfer
  localparam int MAX_REPORTS       = 40;

  // one result transfer, as predicted
  typedef struct packed {
    logic [FPS_W-1:0]   fps_q8;
    logic [FT_W-1:0]    frame_time_ms;
    logic [DELAY_W-1:0] delay_ms;
  } frame_stats_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [NOW_W-1:0]     in_now_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic [FPS_W-1:0]     out_fps_q8;
  logic [FT_W-1:0]      out_frame_time_ms;
  logic [DELAY_W-1:0]   out_delay_ms;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [FPS_CFG_W-1:0] cfg_max_fps;

  frame_rate_meter_limiter #(.WINDOW(RING_DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fps_q8        (out_fps_q8),
    .out_frame_time_ms (out_frame_time_ms),
    .out_delay_ms      (out_delay_ms),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_fps       (cfg_max_fps)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the meter and the limit setting
  // --------------------------------------------------------------------------
  logic [NOW_W-1:0]     begin_stamp;     // tick of the last begin
  logic [NOW_W-1:0]     last_end_stamp;  // tick of the last end
  logic                 have_end;        // an end was seen since reset
  logic [FT_W-1:0]      span_ring [RING_DEPTH];
  int                   span_slot;
  int                   span_fill;
  logic [SUM_W-1:0]     span_sum;
  logic [FPS_CFG_W-1:0] fps_limit;

  frame_stats_t pending_stats [$];   // results still owed by the block
  int           mismatch_count = 0;

  // sender pacing
  bit paced      = 1'b0;
  int burst_left = 0;

  // long receiver hold requests; the receiver process serves them
  int long_stall_requests = 0;

  function automatic void reset_frame_meter();
    begin_stamp    = '0;
    last_end_stamp = '0;
    have_end       = 1'b0;
    span_slot      = 0;
    span_fill      = 0;
    span_sum       = '0;
    fps_limit      = MAX_FPS_RESET;
    foreach (span_ring[i]) span_ring[i] = '0;
  endfunction

  // Advance the predictor by one accepted input transfer. An end queues the
  // stats it must produce; a begin only records its tick.
  function automatic void predict_frame_stats(input logic cmd,
                                              input logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] since_end;
    logic [NOW_W-1:0] elapsed;
    logic [NOW_W-1:0] period;
    logic [63:0]      quot;
    frame_stats_t     s;

    if (cmd == CMD_BEGIN) begin
      begin_stamp = now;
      return;
    end

    // frame time: wrapping difference, saturated; the first end gives 0
    since_end = now - last_end_stamp;
    if (!have_end) s.frame_time_ms = '0;
    else if (since_end > NOW_W'(16'hFFFF)) s.frame_time_ms = 16'hFFFF;
    else s.frame_time_ms = since_end[FT_W-1:0];
    have_end       = 1'b1;
    last_end_stamp = now;

    // ring of the last frame times; once full, the oldest drops out
    if (span_fill >= RING_DEPTH) span_sum = span_sum - SUM_W'(span_ring[span_slot]);
    else span_fill++;
    span_ring[span_slot] = s.frame_time_ms;
    span_sum = span_sum + SUM_W'(s.frame_time_ms);
    span_slot = (span_slot + 1 >= RING_DEPTH) ? 0 : span_slot + 1;

    // averaged rate in Q.8; all-zero times report the default rate and a
    // sub-millisecond average saturates
    if (span_sum == '0) begin
      s.fps_q8 = FPS_DEFAULT;
    end else begin
      quot = (64'(span_fill) * 64'(FPS_SCALE)) / 64'(span_sum);
      s.fps_q8 = (quot > 64'(FPS_SAT)) ? FPS_SAT : quot[FPS_W-1:0];
    end

    // limiter delay; a zero limit counts as 1 frame/s
    period  = NOW_W'(PERIOD_NUM) / ((fps_limit == '0) ? NOW_W'(1) : NOW_W'(fps_limit));
    elapsed = now - begin_stamp;
    s.delay_ms = (period > elapsed) ? DELAY_W'(period - elapsed) : '0;

    pending_stats.push_back(s);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every out transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    frame_stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch($sformatf("unexpected result fps=%0d ft=%0d delay=%0d",
                                  out_fps_q8, out_frame_time_ms, out_delay_ms));
      end else begin
        want = pending_stats.pop_front();
        if (out_fps_q8 !== want.fps_q8)
          report_mismatch($sformatf("fps_q8 got %0d want %0d",
                                    out_fps_q8, want.fps_q8));
        if (out_frame_time_ms !== want.frame_time_ms)
          report_mismatch($sformatf("frame_time_ms got %0d want %0d",
                                    out_frame_time_ms, want.frame_time_ms));
        if (out_delay_ms !== want.delay_ms)
          report_mismatch($sformatf("delay_ms got %0d want %0d",
                                    out_delay_ms, want.delay_ms));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready follows a randomly picked mode (always ready,
  // coin flip, rare stalls, periodic), or a long hold when a test asks.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int served;
    int stall_left;
    int window_left;
    int ready_mode;
    served      = 0;
    stall_left  = 0;
    window_left = 0;
    ready_mode  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != long_stall_requests) begin
        served++;
        stall_left = LONG_STALL_CYCLES;
      end
      if (window_left == 0) begin
        ready_mode  = $urandom_range(0, 3);
        window_left = 64;
      end
      window_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ((window_left % 4) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transfer on any channel ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender. One input transfer per call. valid is left high after the
  // transfer; the next call (or drain_inputs) drives it at the very next
  // falling edge, so callers must not let time pass in between.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [NOW_W-1:0] now);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_now_ms  <= now;
    do @(posedge clk); while (!in_ready);
    predict_frame_stats(cmd, now);
  endtask

  // drop valid and wait for every owed result
  task automatic drain_inputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // Register write only while idle. A trailing begin gives no result, so
  // after the last result we still let an end's worth of cycles pass.
  task automatic set_max_fps(input logic [FPS_CFG_W-1:0] value);
    drain_inputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_max_fps <= value;
    do @(posedge clk); while (!cfg_ready);
    fps_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset defaults: end without begin, first end, zero sum, sub-ms average,
  // delay exactly used up
  task automatic test_first_frames();
    paced = 1'b0;
    send_item(CMD_END,   32'd5);     // first end, elapsed counted from 0
    send_item(CMD_END,   32'd5);     // all stored times 0 -> default rate
    send_item(CMD_END,   32'd6);     // 3 frames in 1 ms -> saturated rate
    send_item(CMD_BEGIN, 32'd100);
    send_item(CMD_END,   32'd116);   // elapsed == period at 60 fps
    send_item(CMD_BEGIN, 32'd200);
    send_item(CMD_END,   32'd201);
  endtask

  // limit register at 0, above 1000, 1000 and 1
  task automatic test_max_fps_extremes();
    paced = 1'b0;
    set_max_fps(10'd0);
    send_item(CMD_BEGIN, 32'd1000);
    send_item(CMD_END,   32'd1000);  // full 1000 ms delay
    set_max_fps(10'd1023);
    send_item(CMD_BEGIN, 32'd2000);
    send_item(CMD_END,   32'd2000);  // period floors to 0
    set_max_fps(10'd1000);
    send_item(CMD_BEGIN, 32'd3000);
    send_item(CMD_END,   32'd3000);
    set_max_fps(10'd1);
    send_item(CMD_BEGIN, 32'd4000);
    send_item(CMD_END,   32'd4500);
  endtask

  // tick wrap, frame time saturation, ring wraparound
  task automatic test_tick_extremes();
    paced = 1'b0;
    send_item(CMD_BEGIN, 32'd0);
    send_item(CMD_END,   32'hFFFF_FFFF);  // huge gap -> 65535
    send_item(CMD_END,   32'h0000_0000);  // wraps, 1 ms
    send_item(CMD_BEGIN, 32'hFFFF_FFF0);
    send_item(CMD_END,   32'h0000_0005);  // elapsed wraps too
    send_item(CMD_END,   32'h0001_0005);  // 65536 -> saturates
    send_item(CMD_END,   32'h0002_0004);  // exactly 65535
    send_item(CMD_END,   32'h0002_0004);
    send_item(CMD_END,   32'h0002_0005);
  endtask

  // Mostly begin/end pairs on a running tick with random render and frame
  // gaps; the rest ends without a begin, stray begins and big jumps.
  task automatic test_random_frames(input int count, input int max_render,
                                    input int max_gap);
    logic [NOW_W-1:0] tick;
    int sent;
    int pick;
    tick = $urandom;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_item(CMD_BEGIN, tick);
        tick += $urandom_range(0, max_render);
        send_item(CMD_END, tick);
        tick += $urandom_range(0, max_gap);
        sent += 2;
      end else if (pick < 88) begin
        tick += $urandom_range(0, max_render);
        send_item(CMD_END, tick);
        sent++;
      end else if (pick < 94) begin
        send_item(CMD_BEGIN, NOW_W'($urandom));
        sent++;
      end else if (pick < 97) begin
        tick += $urandom_range(65536, 1000000);
        send_item(CMD_END, tick);
        sent++;
      end else begin
        send_item(CMD_END, NOW_W'($urandom));
        sent++;
      end
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the result register and sequencer fill and in_ready drops
  task automatic test_output_backpressure();
    paced = 1'b0;
    long_stall_requests++;
    test_random_frames(100, 10, 10);
    paced = 1'b1;
  endtask

  // sender stops until everything owed has arrived, then resumes
  task automatic test_drain_pause();
    paced = 1'b1;
    test_random_frames(40, 30, 30);
    drain_inputs();
    test_random_frames(40, 30, 30);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_BEGIN;
    in_now_ms   = '0;
    cfg_valid   = 1'b0;
    cfg_max_fps = '0;
    reset_frame_meter();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_frames();
    test_max_fps_extremes();
    test_tick_extremes();

    paced = 1'b1;
    set_max_fps(10'd60);
    test_random_frames(270, 3, 2);          // fast frames, big delays
    set_max_fps(10'd1000);
    test_random_frames(270, 40, 30);
    set_max_fps(10'd0);
    test_random_frames(270, 400, 600);
    set_max_fps(10'd1023);
    test_random_frames(270, 20, 20);
    set_max_fps(FPS_CFG_W'($urandom_range(1, 1000)));
    test_random_frames(270, 2000, 70000);   // frame times hit saturation
    set_max_fps(10'd1);
    test_output_backpressure();
    test_drain_pause();
    set_max_fps(FPS_CFG_W'($urandom_range(1, 1000)));
    test_random_frames(270, 60, 40);

    drain_inputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_stats.size() != 0) begin
      frame_stats_t lost;
      lost = pending_stats.pop_front();
      report_mismatch($sformatf("missing result fps=%0d ft=%0d delay=%0d",
                                lost.fps_q8, lost.frame_time_ms, lost.delay_ms));
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/frm_pkg.sv
design/frm_div.sv
design/frm_ring.sv
design/frame_rate_meter_limiter.sv
design/frm_checker.sv
test/tb_top.sv
